// File: sv/atcrr_pkg.sv
// Package for the round-robin tag cache: field widths, command codes and
// the transaction payload types. No dependencies.
package atcrr_pkg;

    localparam int CFG_W     = 5;
    localparam int KEY_W     = 64;
    localparam int SLOT_IO_W = 4;
    localparam int CMD_W     = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [KEY_W-1:0]     key;
        logic [SLOT_IO_W-1:0] slot_in;
    } t_in_item;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_IO_W-1:0] slot_out;
        logic                 evicted;
        logic [KEY_W-1:0]     evicted_key;
        logic                 valid_now;
        logic                 error;
    } t_out_item;

endpackage

// File: sv/atcrr_ifs.sv
// Valid/ready channel interfaces for command and result transactions.
// Depends on atcrr_pkg for the payload types.
interface atcrr_in_if;
    import atcrr_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface atcrr_out_if;
    import atcrr_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/assoc_tag_cache_round_robin.sv
// Top level of the round-robin tag cache: command sequencer, tag scan,
// valid/present flags and result register. Depends on atcrr_pkg,
// atcrr_ifs and atcrr_tag_ram.
//
//   port         dir  payload                                     kind
//   i_in         in   command, key, slot_in                       valid/ready
//   o_out        out  hit, slot_out, evicted, evicted_key,        valid/ready
//                     valid_now, error
//   i_cfg_we/    in   slots_in_use                                write only
//   i_cfg_wdata
//
// A get reads one tag per slot through the single read port of the tag memory and,
// on a miss, writes the key back to the victim slot in the final state; a hit
// ends the scan early. Query, mark and the unused command skip the scan.
// Reset clears the flags and the victim pointer and sets the slot count to 16;
// no clear pass.
// A held result stalls the sequencer in its final state; the next command
// is taken once the sequencer is back in idle after the result is registered.
module assoc_tag_cache_round_robin #(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [atcrr_pkg::CFG_W-1:0] i_cfg_wdata,
    atcrr_in_if.sink                    i_in,
    atcrr_out_if.source                 o_out
);
    import atcrr_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW     = ($clog2(SLOTS + 1) + 1 > CFG_W) ? $clog2(SLOTS + 1) + 1 : CFG_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_slots_in_use;
    logic [SLOT_W-1:0]     r_ptr;
    logic [SLOTS-1:0]      r_valid;
    logic [SLOTS-1:0]      r_present;
    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [SLOT_IO_W-1:0]  r_slot_in;
    logic [SLOT_W-1:0]     r_scan_idx;
    logic                  r_hit;
    logic [SLOT_W-1:0]     r_slot;
    logic [KEY_BITS-1:0]   r_vic_tag;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [CW-1:0]         w_count;
    logic [CW-1:0]         w_cfg_cw;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_finish;
    logic [KEY_BITS-1:0]   w_rd_data;
    logic                  w_rd_en;
    logic [SLOT_W-1:0]     w_rd_addr;
    logic                  w_match;
    logic                  w_last;
    logic [SLOT_W-1:0]     w_victim;
    logic [CW-1:0]         w_vic_next;
    logic [SLOT_W-1:0]     n_ptr;
    logic                  w_wr_en;
    logic [CW-1:0]         w_slot_in_cw;
    logic [SLOT_W-1:0]     w_qidx;
    logic                  w_in_range;
    logic [CW-1:0]         w_slot_cw;
    logic [CW-1:0]         w_victim_cw;
    t_out_item             w_res;

    assign w_cfg_cw = CW'(r_slots_in_use);
    assign w_count  = (r_slots_in_use == '0) ? CW'(1) :
                      (w_cfg_cw > CW'(SLOTS)) ? CW'(SLOTS) : w_cfg_cw;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_finish    = (r_state == ST_DONE) && w_out_free;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_match = r_present[r_scan_idx] && (w_rd_data == r_key);
    assign w_last  = (CW'(r_scan_idx) + CW'(1)) >= w_count;

    assign w_victim    = (CW'(r_ptr) < w_count) ? r_ptr : '0;
    assign w_victim_cw = CW'(w_victim);
    assign w_vic_next  = w_victim_cw + CW'(1);
    assign n_ptr       = (w_vic_next >= w_count) ? '0 : w_vic_next[SLOT_W-1:0];

    assign w_slot_in_cw = CW'(r_slot_in);
    assign w_qidx       = w_slot_in_cw[SLOT_W-1:0];
    assign w_in_range   = w_slot_in_cw < w_count;
    assign w_slot_cw    = CW'(r_slot);

    assign w_wr_en = w_finish && (r_cmd == CMD_GET) && !r_hit;

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_scan_idx + SLOT_W'(1);
        if (w_accept && (i_in.data.command == CMD_GET)) begin
            w_rd_en   = 1'b1;
            w_rd_addr = '0;
        end else if ((r_state == ST_SCAN) && !w_match && !w_last) begin
            w_rd_en = 1'b1;
        end
    end

    atcrr_tag_ram #(
        .DEPTH  (SLOTS),
        .WIDTH  (KEY_BITS),
        .ADDR_W (SLOT_W)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_we      (w_wr_en),
        .i_wr_addr (w_victim),
        .i_wr_data (r_key),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.data.command == CMD_GET) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (w_match || w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_res = '0;
        unique case (r_cmd) inside
            CMD_GET: begin
                w_res.hit = r_hit;
                if (r_hit) begin
                    w_res.slot_out  = w_slot_cw[SLOT_IO_W-1:0];
                    w_res.valid_now = r_valid[r_slot];
                end else begin
                    w_res.slot_out = w_victim_cw[SLOT_IO_W-1:0];
                    w_res.evicted  = r_valid[w_victim];
                    if (r_valid[w_victim]) begin
                        w_res.evicted_key = KEY_W'(r_vic_tag);
                    end
                end
            end
            CMD_QUERY, CMD_MARK: begin
                w_res.slot_out = r_slot_in;
                if (w_in_range) begin
                    if (r_cmd == CMD_MARK) begin
                        w_res.error     = r_valid[w_qidx];
                        w_res.valid_now = 1'b1;
                    end else begin
                        w_res.valid_now = r_valid[w_qidx];
                    end
                end
            end
            default: w_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_slots_in_use <= CFG_RESET;
            r_ptr          <= '0;
            r_valid        <= '0;
            r_present      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_slots_in_use <= i_cfg_wdata;
            end
            if (w_wr_en) begin
                r_ptr               <= n_ptr;
                r_present[w_victim] <= 1'b1;
                r_valid[w_victim]   <= 1'b0;
            end
            if (w_finish && (r_cmd == CMD_MARK) && w_in_range) begin
                r_valid[w_qidx] <= 1'b1;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= i_in.data.command;
            r_key      <= i_in.data.key[KEY_BITS-1:0];
            r_slot_in  <= i_in.data.slot_in;
            r_scan_idx <= '0;
            r_hit      <= 1'b0;
        end
        if (r_state == ST_SCAN) begin
            if (r_scan_idx == w_victim) begin
                r_vic_tag <= w_rd_data;
            end
            if (w_match) begin
                r_hit  <= 1'b1;
                r_slot <= r_scan_idx;
            end else if (!w_last) begin
                r_scan_idx <= r_scan_idx + SLOT_W'(1);
            end
        end
        if (w_finish) begin
            r_out <= w_res;
        end
    end

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CW'(r_scan_idx) < w_count))
        else $error("scan index beyond slot count");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (CW'(r_ptr) < w_count))
        else $error("victim pointer beyond slot count after allocate");

    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.evicted) |-> !o_out.data.hit)
        else $error("eviction reported on a hit");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside the final state");

    a_write_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> ((r_cmd == CMD_GET) && !r_hit && (r_state == ST_DONE)))
        else $error("tag write without a get miss");

endmodule

// File: sv/atcrr_tag_ram.sv
// Tag memory: one write port, one read port with registered read data.
// No dependencies.
module atcrr_tag_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: bench/tb_assoc_tag_cache_round_robin.sv
`timescale 1ns / 100ps
// Testbench for assoc_tag_cache_round_robin: a directed table, then random phases at several
// slot counts, each result checked against its table answer or a local tag/valid predictor.
// Depends on atcrr_pkg, atcrr_ifs and the block's RTL.
module tb_assoc_tag_cache_round_robin;
    import atcrr_pkg::*;

    localparam int SLOTS = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int POOL_KEYS = 24;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
    localparam bit ROW_ITEM = 1'b0;
    localparam bit ROW_CFG = 1'b1;

    typedef struct packed {
        bit                   is_cfg;
        logic [CFG_W-1:0]     cfg;
        t_in_item             item;
        bit                   typed;
        t_out_item            answer;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    atcrr_in_if  in_ch ();
    atcrr_out_if out_ch ();

    assoc_tag_cache_round_robin dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    logic [KEY_W-1:0] tags_m [SLOTS];
    bit               present_m [SLOTS];
    bit               valid_m [SLOTS];
    int               victim_ptr_m;
    logic [CFG_W-1:0] slots_cfg_m;

    t_out_item        awaited_answers [$];
    t_dir_row         table_rows [$];
    logic [KEY_W-1:0] key_pool [POOL_KEYS];
    logic [CFG_W-1:0] phase_slots [PHASES];
    int               mismatches;
    bit               steady;
    bit               hold_off_req;
    int               ready_wait;
    t_out_item        want;
    t_out_item        got;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int active_slots();
        if (slots_cfg_m == 0) return 1;
        if (slots_cfg_m > SLOTS) return SLOTS;
        return int'(slots_cfg_m);
    endfunction

    function automatic t_out_item run_tag_cache(input t_in_item it);
        t_out_item r;
        int n;
        int victim;
        bit found;
        r = '0;
        n = active_slots();
        found = 1'b0;
        case (it.command)
            CMD_GET: begin
                for (int i = 0; i < n; i++) begin
                    if (!found && present_m[i] && tags_m[i] == it.key) begin
                        found = 1'b1;
                        r.hit = 1'b1;
                        r.slot_out = SLOT_IO_W'(i);
                        r.valid_now = valid_m[i];
                    end
                end
                if (!found) begin
                    victim = (victim_ptr_m < n) ? victim_ptr_m : 0;
                    victim_ptr_m = (victim + 1 >= n) ? 0 : victim + 1;
                    if (valid_m[victim]) begin
                        r.evicted = 1'b1;
                        r.evicted_key = tags_m[victim];
                    end
                    tags_m[victim] = it.key;
                    present_m[victim] = 1'b1;
                    valid_m[victim] = 1'b0;
                    r.slot_out = SLOT_IO_W'(victim);
                end
            end
            CMD_QUERY, CMD_MARK: begin
                r.slot_out = it.slot_in;
                if (int'(it.slot_in) < n) begin
                    if (it.command == CMD_MARK) begin
                        r.error = valid_m[it.slot_in];
                        valid_m[it.slot_in] = 1'b1;
                    end
                    r.valid_now = valid_m[it.slot_in];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_dir_row mk(input bit is_cfg, input logic [CFG_W-1:0] cfg,
                                    input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                    input logic [SLOT_IO_W-1:0] slot, input int typed,
                                    input int hit, input logic [SLOT_IO_W-1:0] slot_out,
                                    input int evicted, input logic [KEY_W-1:0] evicted_key,
                                    input int valid_now, input int error);
        t_dir_row r;
        r.is_cfg = is_cfg;
        r.cfg = cfg;
        r.item.command = cmd;
        r.item.key = key;
        r.item.slot_in = slot;
        r.typed = (typed != 0);
        r.answer.hit = (hit != 0);
        r.answer.slot_out = slot_out;
        r.answer.evicted = (evicted != 0);
        r.answer.evicted_key = evicted_key;
        r.answer.valid_now = (valid_now != 0);
        r.answer.error = (error != 0);
        return r;
    endfunction

    function automatic t_in_item next_random_item();
        t_in_item it;
        int pick;
        int n;
        n = active_slots();
        it.key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                            : {$urandom, $urandom};
        it.slot_in = SLOT_IO_W'($urandom_range(0, SLOTS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.command = CMD_GET;
        end else if (pick < 70) begin
            it.command = CMD_QUERY;
        end else if (pick < 95) begin
            it.command = CMD_MARK;
            if (pick < 90) it.slot_in = SLOT_IO_W'($urandom_range(0, n - 1));
            // never mark a slot whose tag was never written
            if (int'(it.slot_in) < n && !present_m[it.slot_in]) it.command = CMD_QUERY;
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [KEY_W-1:0] exp_v,
                                        input logic [KEY_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    task automatic drive_item(input t_in_item it, input bit typed, input t_out_item answer);
        int gap;
        t_out_item pred;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        pred = run_tag_cache(it);
        awaited_answers.push_back(typed ? answer : pred);
    endtask

    task automatic set_slot_count(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        slots_cfg_m = value;
    endtask

    // receiver: per-transaction stall, plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else if (ready_wait > 0) begin
                ready_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (awaited_answers.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                mismatches++;
            end else begin
                want = awaited_answers.pop_front();
                check_field("hit", want.hit, got.hit);
                check_field("slot_out", want.slot_out, got.slot_out);
                check_field("evicted", want.evicted, got.evicted);
                check_field("evicted_key", want.evicted_key, got.evicted_key);
                check_field("valid_now", want.valid_now, got.valid_now);
                check_field("error", want.error, got.error);
            end
            ready_wait = steady ? 0 : $urandom_range(0, 3);
        end
    end

    initial begin
        #5_000_000;
        $display("assoc_tag_cache_round_robin test failed");
        $finish;
    end

    initial begin
        t_dir_row r;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        mismatches = 0;
        steady = 1'b0;
        hold_off_req = 1'b0;
        ready_wait = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tags_m[i] = '0;
            present_m[i] = 1'b0;
            valid_m[i] = 1'b0;
        end
        victim_ptr_m = 0;
        slots_cfg_m = CFG_RESET;
        for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = KEY_ONES;
        phase_slots = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd31, 5'd2, 5'd17, 5'd12};

        table_rows = '{
            mk(ROW_ITEM, 5'd0, CMD_QUERY, 64'h0, 4'd0, 1, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_GET, 64'h0, 4'd0, 1, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_GET, KEY_ONES, 4'd0, 1, 0, 4'd1, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_GET, 64'h0, 4'd0, 1, 1, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_MARK, 64'h0, 4'd0, 1, 0, 4'd0, 0, 64'h0, 1, 0),
            mk(ROW_ITEM, 5'd0, CMD_MARK, 64'h0, 4'd0, 1, 0, 4'd0, 0, 64'h0, 1, 1),
            mk(ROW_ITEM, 5'd0, CMD_QUERY, 64'h0, 4'd1, 0, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_MARK, 64'h0, 4'd1, 0, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_GET, 64'h0, 4'd0, 0, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_UNUSED, KEY_ONES, 4'd15, 1, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_QUERY, 64'h0, 4'd15, 1, 0, 4'd15, 0, 64'h0, 0, 0),
            mk(ROW_CFG, 5'd2, CMD_GET, 64'h0, 4'd0, 0, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_GET, 64'h1234, 4'd0, 1, 0, 4'd0, 1, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_GET, 64'h5555_5555_5555_5555, 4'd0, 1,
               0, 4'd1, 1, KEY_ONES, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_QUERY, 64'h0, 4'd2, 1, 0, 4'd2, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_MARK, 64'h0, 4'd3, 1, 0, 4'd3, 0, 64'h0, 0, 0),
            mk(ROW_CFG, 5'd0, CMD_GET, 64'h0, 4'd0, 0, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_GET, 64'hAAAA_AAAA_AAAA_AAAA, 4'd0, 0,
               0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_GET, 64'h5555_5555_5555_5555, 4'd0, 0,
               0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_CFG, 5'd31, CMD_GET, 64'h0, 4'd0, 0, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_GET, 64'h5555_5555_5555_5555, 4'd0, 0,
               0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_MARK, 64'h0, 4'd1, 0, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_QUERY, 64'h0, 4'd15, 0, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_CFG, 5'd17, CMD_GET, 64'h0, 4'd0, 0, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_GET, 64'h1, 4'd0, 0, 0, 4'd0, 0, 64'h0, 0, 0),
            mk(ROW_ITEM, 5'd0, CMD_GET, 64'h8000_0000_0000_0000, 4'd0, 0,
               0, 4'd0, 0, 64'h0, 0, 0)
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (table_rows[i]) begin
            r = table_rows[i];
            if (r.is_cfg) begin
                set_slot_count(r.cfg);
            end else begin
                drive_item(r.item, r.typed, r.answer);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            set_slot_count(phase_slots[p]);
            steady = (p % 3 == 2);
            // stall the result side while commands keep coming
            if (p == 1) hold_off_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                drive_item(next_random_item(), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("assoc_tag_cache_round_robin test passed");
        end else begin
            $display("assoc_tag_cache_round_robin test failed");
        end
        $finish;
    end
endmodule
